// ----- sv/bcdd_pkg.sv -----
// Shared types and constants for the BCD display digit driver.
// No dependencies; imported by bcdd_ctrl, bcdd_dp and bcd_display_digit_driver.
package bcdd_pkg;

    localparam int VALUE_W        = 32;
    localparam int DIGIT_W        = 4;
    localparam int QUOT_SHIFT     = 35;
    localparam int QUOT_W         = 2 * VALUE_W - QUOT_SHIFT;
    localparam int DEF_MAX_DIGITS = 10;

    // floor(x * RECIP_TEN / 2^35) == x / 10 for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam logic [DIGIT_W-1:0] COUNT_RST  = 4'd3;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic count_zero;
    } t_status;

endpackage

// ----- sv/bcd_display_digit_driver.sv -----
// Takes a 32-bit unsigned word and sends out its decimal digits, least significant first,
// one output word per digit with the display index and a last flag; the value is shown
// modulo 10^digit_count (count saturates at MAX_DIGITS, zero yields no output). Each digit
// takes a reciprocal multiply step and a remainder step; the remainder step waits while a
// stalled word sits in the output register. A new word is taken once the previous value's
// last digit sits in the output register. Depends on bcdd_pkg, bcdd_ctrl, bcdd_dp.
module bcd_display_digit_driver #(
    parameter int MAX_DIGITS = bcdd_pkg::DEF_MAX_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bcdd_pkg::DIGIT_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bcdd_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bcdd_pkg::DIGIT_W-1:0]  o_bcd_code,
    output logic [bcdd_pkg::DIGIT_W-1:0]  o_display_index,
    output logic                          o_last
);
    import bcdd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    bcdd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    bcdd_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_value         (i_value),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_bcd_code      (o_bcd_code),
        .o_display_index (o_display_index),
        .o_last          (o_last)
    );

`ifndef SYNTHESIS
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bcd_code <= DIGIT_W'(9)))
        else $error("bcd digit out of range");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_display_index < DIGIT_W'(MAX_DIGITS)))
        else $error("display index beyond digit limit");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && w_status.count_zero) |=> !o_stall)
        else $error("zero digit count did not return to idle");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !w_status.count_zero) |=> o_stall)
        else $error("accepted word did not start conversion");
`endif

endmodule

// ----- sv/bcdd_dp.sv -----
// Datapath: digit count register, remaining value, reciprocal divide by ten,
// digit index counter and output word register. Depends on bcdd_pkg.
module bcdd_dp #(
    parameter int MAX_DIGITS = bcdd_pkg::DEF_MAX_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bcdd_pkg::DIGIT_W-1:0]  i_cfg_data,
    input  logic [bcdd_pkg::VALUE_W-1:0]  i_value,
    input  bcdd_pkg::t_cmd                i_cmd,
    output bcdd_pkg::t_status             o_status,
    output logic [bcdd_pkg::DIGIT_W-1:0]  o_bcd_code,
    output logic [bcdd_pkg::DIGIT_W-1:0]  o_display_index,
    output logic                          o_last
);
    import bcdd_pkg::*;

    logic [DIGIT_W-1:0]   r_count;
    logic [DIGIT_W-1:0]   w_count_eff;
    logic [VALUE_W-1:0]   r_rest;
    logic [QUOT_W-1:0]    r_quot;
    logic [DIGIT_W-1:0]   r_idx;
    logic [DIGIT_W-1:0]   r_bcd;
    logic [DIGIT_W-1:0]   r_didx;
    logic                 r_last;
    logic [2*VALUE_W-1:0] w_prod;
    logic [DIGIT_W-1:0]   w_q_lo;
    logic [DIGIT_W-1:0]   w_digit;
    logic                 w_last;

    assign w_count_eff = (r_count > DIGIT_W'(MAX_DIGITS)) ? DIGIT_W'(MAX_DIGITS) : r_count;
    assign w_prod      = {{VALUE_W{1'b0}}, r_rest} * {{VALUE_W{1'b0}}, RECIP_TEN};
    // remainder is below ten, so the low nibble is enough
    assign w_q_lo      = r_quot[DIGIT_W-1:0];
    assign w_digit     = r_rest[DIGIT_W-1:0] - ((w_q_lo << 3) + (w_q_lo << 1));
    assign w_last      = (r_idx == (w_count_eff - DIGIT_W'(1)));

    assign o_status.last       = w_last;
    assign o_status.count_zero = (w_count_eff == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RST;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest <= i_value;
            r_idx  <= '0;
        end
        if (i_cmd.mul) begin
            r_quot <= w_prod[2*VALUE_W-1:QUOT_SHIFT];
        end
        if (i_cmd.step) begin
            r_rest <= {{(VALUE_W-QUOT_W){1'b0}}, r_quot};
            r_idx  <= r_idx + DIGIT_W'(1);
            r_bcd  <= w_digit;
            r_didx <= r_idx;
            r_last <= w_last;
        end
    end

    assign o_bcd_code      = r_bcd;
    assign o_display_index = r_didx;
    assign o_last          = r_last;

endmodule

// ----- sv/bcdd_ctrl.sv -----
// Controller: sequences load, multiply and digit steps, and owns both handshakes.
// Depends on bcdd_pkg.
module bcdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  bcdd_pkg::t_status i_status,
    output bcdd_pkg::t_cmd    o_cmd
);
    import bcdd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIG
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_out_free;

    assign w_out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        n_ovalid   = r_ovalid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.count_zero) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIG;
            end
            S_DIG: begin
                if (w_out_free) begin
                    o_cmd.step = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = i_status.last ? S_IDLE : S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule
